// ===== hdl/b85enc_pkg.sv =====
// b85enc_pkg: shared types and constants for the base-85 byte encoder.
// No dependencies; used by every module of the encoder.

package b85enc_pkg;

    // Base-85 digit coding
    localparam int unsigned RADIX      = 85;
    localparam int unsigned DIGITS     = 5;
    localparam logic [6:0]  FIRST_CHAR = 7'h21;   // '!'
    localparam logic [6:0]  ZERO_CHAR  = 7'h7A;   // 'z'

    // floor(v / 85) == (v * RECIP) >> RECIP_SHIFT for every 32-bit v
    localparam logic [31:0] RECIP       = 32'hC0C0_C0C1;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam int unsigned QUOT_W      = 64 - RECIP_SHIFT;

    // Request queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One group, classified by the front
    typedef struct packed {
        logic [31:0] value;     // big-endian group, zero padded
        logic [2:0]  count;     // characters to emit, 1..5
        logic        zero;      // group value is zero: emit 'z'
    } job_t;

endpackage

// ===== hdl/b85enc_front.sv =====
// b85enc_front: packs input bytes into groups and classifies each closed group.
// Depends on b85enc_pkg (job_t, DIGITS).

module b85enc_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic               pad_final_group,
    output logic               push,
    output b85enc_pkg::job_t   push_job
);

    logic [23:0] group_reg;
    logic [23:0] group_next;
    logic [1:0]  held_reg;
    logic [1:0]  held_next;
    logic        accept;
    logic        close;
    logic [31:0] packed_val;
    logic [31:0] aligned_val;

    assign accept     = in_valid & ~in_stall;
    assign close      = last_byte | (held_reg == 2'd3);
    assign packed_val = {group_reg, data_byte};

    // Left-align a short group, zeros fill the tail
    always_comb
    begin
        case (held_reg)
            2'd0:    aligned_val = {packed_val[7:0], 24'd0};
            2'd1:    aligned_val = {packed_val[15:0], 16'd0};
            2'd2:    aligned_val = {packed_val[23:0], 8'd0};
            default: aligned_val = packed_val;
        endcase
    end

    // Classify the closed group
    always_comb
    begin
        push_job.value = aligned_val;
        push_job.zero  = (aligned_val == 32'd0);
        if (aligned_val == 32'd0)
        begin
            push_job.count = 3'd1;
        end
        else if ((held_reg == 2'd3) || pad_final_group)
        begin
            push_job.count = 3'(b85enc_pkg::DIGITS);
        end
        else
        begin
            push_job.count = {1'b0, held_reg} + 3'd2;
        end
    end

    assign push = accept & close;

    // Group accumulation
    always_comb
    begin
        group_next = group_reg;
        held_next  = held_reg;
        if (accept)
        begin
            if (close)
            begin
                group_next = 24'd0;
                held_next  = 2'd0;
            end
            else
            begin
                group_next = {group_reg[15:0], data_byte};
                held_next  = held_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= 24'd0;
            held_reg  <= 2'd0;
        end
        else
        begin
            group_reg <= group_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== hdl/b85enc_queue.sv =====
// b85enc_queue: short request queue of classified groups between front and back.
// Depends on b85enc_pkg (job_t, queue sizing).

module b85enc_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b85enc_pkg::job_t   push_job,
    input  logic               pop,
    output logic               not_empty,
    output logic               full,
    output b85enc_pkg::job_t   head
);

    b85enc_pkg::job_t                    entry_reg [b85enc_pkg::QUEUE_DEPTH];
    logic [b85enc_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [b85enc_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [b85enc_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [b85enc_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [b85enc_pkg::QCNT_W-1:0]       count_reg;
    logic [b85enc_pkg::QCNT_W-1:0]       count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == b85enc_pkg::QCNT_W'(b85enc_pkg::QUEUE_DEPTH));
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == b85enc_pkg::QPTR_W'(b85enc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == b85enc_pkg::QPTR_W'(b85enc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/b85enc_back.sv =====
// b85enc_back: converts queued groups to base-85 digits and emits characters.
// Depends on b85enc_pkg (job_t, digit count, reciprocal constants, character codes).

module b85enc_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               not_empty,
    input  b85enc_pkg::job_t   head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [6:0]         out_char,
    output logic               last_char
);

    localparam int unsigned LAST_DIG = b85enc_pkg::DIGITS - 1;

    // Converter state
    logic                             cv_busy_reg;
    logic                             cv_busy_next;
    logic                             cv_done_reg;
    logic                             cv_done_next;
    logic [2:0]                       cv_step_reg;
    logic [2:0]                       cv_step_next;
    logic [2:0]                       cv_cnt_reg;
    logic                             cv_zero_reg;
    logic [31:0]                      dvd_reg;
    logic [63:0]                      prod_reg;
    logic [6:0]                       cv_dig_reg [b85enc_pkg::DIGITS];

    // Emitter state
    logic [2:0]                       em_cnt_reg;
    logic [2:0]                       em_cnt_next;
    logic                             em_zero_reg;
    logic [6:0]                       em_dig_reg [b85enc_pkg::DIGITS];

    // Output register
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [6:0]                       out_char_reg;
    logic                             last_char_reg;

    logic                             take;
    logic                             emit;
    logic                             digit_step;
    logic [31:0]                      mul_in;
    logic [63:0]                      mul_prod;
    logic [b85enc_pkg::QUOT_W-1:0]    quot;
    logic [31:0]                      quot_w;
    logic [31:0]                      quot_x85;
    logic [31:0]                      rem_full;
    logic [6:0]                       digit;

    // Handoff and emit strobes
    assign take       = cv_done_reg && (em_cnt_reg == 3'd0);
    assign pop        = not_empty && !cv_busy_reg && (!cv_done_reg || take);
    assign emit       = (em_cnt_reg != 3'd0) && (!out_valid_reg || !out_stall);
    assign digit_step = cv_busy_reg && (cv_step_reg != 3'd0);

    // Shared divide-by-85: one reciprocal multiply per cycle
    assign quot     = prod_reg[63:b85enc_pkg::RECIP_SHIFT];
    assign quot_w   = 32'(quot);
    assign mul_in   = pop ? head.value : quot_w;
    assign mul_prod = {32'd0, mul_in} * {32'd0, b85enc_pkg::RECIP};

    // Remainder: dividend - 85 * quotient (85 = 64 + 16 + 4 + 1)
    assign quot_x85 = (quot_w << 6) + (quot_w << 4) + (quot_w << 2) + quot_w;
    assign rem_full = dvd_reg - quot_x85;
    assign digit    = rem_full[6:0];

    // Converter sequencing
    always_comb
    begin
        cv_busy_next = cv_busy_reg;
        cv_done_next = cv_done_reg;
        cv_step_next = cv_step_reg;
        if (take)
        begin
            cv_done_next = 1'b0;
        end
        if (pop)
        begin
            if (head.zero)
            begin
                cv_done_next = 1'b1;
            end
            else
            begin
                cv_busy_next = 1'b1;
                cv_step_next = 3'd1;
            end
        end
        else if (digit_step)
        begin
            if (cv_step_reg == 3'(b85enc_pkg::DIGITS))
            begin
                cv_busy_next = 1'b0;
                cv_done_next = 1'b1;
                cv_step_next = 3'd0;
            end
            else
            begin
                cv_step_next = cv_step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_busy_reg <= 1'b0;
            cv_done_reg <= 1'b0;
            cv_step_reg <= 3'd0;
        end
        else
        begin
            cv_busy_reg <= cv_busy_next;
            cv_done_reg <= cv_done_next;
            cv_step_reg <= cv_step_next;
        end
    end

    // Converter datapath; digits shift in least significant first
    always_ff @(posedge clk)
    begin
        if (pop || digit_step)
        begin
            prod_reg <= mul_prod;
            dvd_reg  <= mul_in;
        end
        if (pop)
        begin
            cv_cnt_reg  <= head.count;
            cv_zero_reg <= head.zero;
        end
        if (digit_step)
        begin
            for (int i = LAST_DIG; i > 0; i--)
            begin
                cv_dig_reg[i] <= cv_dig_reg[i-1];
            end
            cv_dig_reg[0] <= digit;
        end
    end

    // Emitter count
    always_comb
    begin
        em_cnt_next = em_cnt_reg;
        if (take)
        begin
            em_cnt_next = cv_cnt_reg;
        end
        else if (emit)
        begin
            em_cnt_next = em_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_cnt_reg <= 3'd0;
        end
        else
        begin
            em_cnt_reg <= em_cnt_next;
        end
    end

    // Emitter digits, most significant at position 0
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            em_zero_reg <= cv_zero_reg;
            for (int i = 0; i < b85enc_pkg::DIGITS; i++)
            begin
                em_dig_reg[i] <= cv_dig_reg[i];
            end
        end
        else if (emit)
        begin
            for (int i = 0; i < LAST_DIG; i++)
            begin
                em_dig_reg[i] <= em_dig_reg[i+1];
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_char_reg  <= em_zero_reg ? b85enc_pkg::ZERO_CHAR
                                         : em_dig_reg[0] + b85enc_pkg::FIRST_CHAR;
            last_char_reg <= (em_cnt_reg == 3'd1);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;

endmodule

// ===== hdl/base85_byte_encoder_core.sv =====
// base85_byte_encoder_core: top level of the base-85 byte encoder.
// Depends on b85enc_pkg, b85enc_front, b85enc_queue and b85enc_back.
//
//  Channel   Handshake                Payload
//  -------   ----------------------   -----------------------------
//  input     in_valid / in_stall      data_byte[7:0], last_byte
//  output    out_valid / out_stall    out_char[6:0], last_char
//  config    cfg_wr_en                cfg_wr_data (pad_final_group)
//
// A byte is taken every cycle while the two-entry group queue has room.
// Each group is loaded into the shared reciprocal divide-by-85 unit, which
// then produces its five digits least significant first, before up to five
// characters are output; conversion of one group overlaps output of the
// previous. A zero group skips the divider.
// Reset clears the partial group, the queue and all pending output.
// out_stall holds the output register; the back end and then the queue fill
// before in_stall rises.

module base85_byte_encoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  out_char,
    output logic        last_char
);

    logic               pad_reg;
    logic               push;
    logic               pop;
    logic               not_empty;
    logic               full;
    b85enc_pkg::job_t   push_job;
    b85enc_pkg::job_t   head;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            pad_reg <= cfg_wr_data;
        end
    end

    assign in_stall = full;

    // Front: group packing and classification
    b85enc_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .pad_final_group (pad_reg),
        .push            (push),
        .push_job        (push_job)
    );

    // Request queue
    b85enc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_empty (not_empty),
        .full      (full),
        .head      (head)
    );

    // Back: digit conversion and character output
    b85enc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule
